// File: rtl/ckdf_pkg.sv
// Shared constants, types and functions for the Concat KDF SHA-256 block.
`timescale 1ns / 1ps
package ckdf_pkg;

  localparam int unsigned MessageBytesDef = 256;
  localparam int unsigned MaxKeyBytesDef  = 512;
  localparam int unsigned KeyLenW         = 10;
  localparam logic [KeyLenW-1:0] KeyLenReset = 10'd32;

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constant lookup.
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  // Control from the sequencer to the compression core.
  typedef struct packed {
    logic init;   // load initial chaining value
    logic start;  // start compressing the loaded block
  } core_ctrl_t;

endpackage

// File: rtl/concat_kdf_sha256_top.sv
// Top level of the Concat KDF SHA-256 block: message store, sequencer, output.
`timescale 1ns / 1ps
// Bytes load one per cycle (one transfer per clock while collecting). On the
// transfer with tlast the block derives the key: each 32-byte digest takes one
// SHA-256 pass. A pass first waits out the store's read latency, then for
// every 64-byte block of the padded message it feeds 64 bytes, one per cycle,
// from the store's single read port and then runs the shared round unit
// (start, 64 rounds, chaining add, hand-back); a pass covers
// ceil((total bytes + 13) / 64) blocks. Key words then leave one per
// accepted transfer, up to four per pass. No input is taken during derivation;
// the last key word may still wait for the receiver while the next message loads.
module concat_kdf_sha256_top #(
  parameter int unsigned MESSAGE_BYTES = ckdf_pkg::MessageBytesDef,
  parameter int unsigned MAX_KEY_BYTES = ckdf_pkg::MaxKeyBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,      // key_length_bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,     // [7:0] data_byte, [8] byte_present, zero fill
  input  logic        s_axis_tuser,     // part_select
  input  logic        s_axis_tlast,     // message_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,     // [63:0] key_word, [67:64] valid_bytes, zero fill
  output logic        m_axis_tuser,     // overflow_error
  output logic        m_axis_tlast      // last_word
);

  localparam int unsigned AW   = $clog2(MESSAGE_BYTES);
  localparam int unsigned LW   = AW + 1;
  localparam int unsigned KW   = $clog2(MAX_KEY_BYTES + 1);

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_FEED  = 6'b000010,
    S_COMP  = 6'b000100,
    S_EMIT  = 6'b001000,
    S_ERR   = 6'b010000,
    S_WAIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [9:0]    klen_q;
  logic [7:0]    mem [MESSAGE_BYTES];
  logic [7:0]    rd_q;
  logic [LW-1:0] tot_q, tot_d;
  logic          ovf_q, ovf_d;

  // Pass feeding counters.
  logic [LW+3:0] pos_q, pos_d;    // byte position in the padded stream
  logic [LW+3:0] padlen_q;        // padded length in bytes
  logic [5:0]    fill_q, fill_d;
  logic [511:0]  blk_q, blk_d;
  logic [KW-1:0] cnt_q, cnt_d;    // counter value of the pass
  logic [KW-1:0] got_q, got_d;    // key bytes produced
  logic [KW-1:0] need;
  logic [255:0]  dig_q, dig_d;
  logic [1:0]    word_q, word_d;  // 64-bit word index within a digest
  logic          rd_valid_q;

  ckdf_pkg::core_ctrl_t ctrl;
  logic          core_busy;
  logic [255:0]  digest;

  logic [71:0]   out_q, out_d;
  logic          olast_q, olast_d, ouser_q, ouser_d, ovalid_q, ovalid_d;

  logic          in_fire;
  logic [7:0]    feed_byte;
  logic [LW+6:0] bits;
  logic [LW+3:0] msg_end;
  logic [KW-1:0] rem;
  logic [3:0]    nbytes;
  logic [63:0]   kw;

  ckdf_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .block_i (blk_q),
    .busy_o  (core_busy),
    .digest_o(digest)
  );

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_LOAD);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = ouser_q;

  // Effective key length: zero means one, large values saturate.
  always_comb begin
    need = KW'(klen_q);
    if (klen_q == 10'd0) need = KW'(1);
    if ({1'b0, klen_q} > 11'(MAX_KEY_BYTES)) need = KW'(MAX_KEY_BYTES);
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) klen_q <= ckdf_pkg::KeyLenReset;
    else if (cfg_we_i) klen_q <= cfg_wdata_i;
  end

  // Message store: written while loading, read one byte per feed cycle.
  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tdata[8] && (tot_q < LW'(MESSAGE_BYTES))) begin
      mem[tot_q[AW-1:0]] <= s_axis_tdata[7:0];
    end
    rd_q <= mem[pos_d[AW-1:0] - AW'(4)];
  end

  // Byte of the padded stream at pos_q.
  assign msg_end = (LW+4)'(tot_q) + (LW+4)'(4);
  assign bits    = (LW+7)'(msg_end) << 3;
  always_comb begin
    if (pos_q < (LW+4)'(4)) feed_byte = 8'(32'(cnt_q) >> {~pos_q[1:0], 3'b000});
    else if (pos_q < msg_end) feed_byte = rd_q;
    else if (pos_q == msg_end) feed_byte = 8'h80;
    else if (pos_q == padlen_q - (LW+4)'(2)) feed_byte = 8'((32'(bits)) >> 8);
    else if (pos_q == padlen_q - (LW+4)'(1)) feed_byte = 8'(bits);
    else feed_byte = 8'd0;
  end

  // Output word from the current digest.
  always_comb begin
    rem = need - got_q;
    nbytes = (rem >= KW'(8)) ? 4'd8 : 4'(rem);
    kw = dig_q[255 - 64*word_q -: 64];
    for (int j = 0; j < 8; j++) begin
      if (4'(j) >= nbytes) kw[63 - 8*j -: 8] = 8'd0;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    tot_d = tot_q; ovf_d = ovf_q;
    pos_d = pos_q; fill_d = fill_q; blk_d = blk_q;
    cnt_d = cnt_q; got_d = got_q; dig_d = dig_q; word_d = word_q;
    out_d = out_q; olast_d = olast_q; ouser_d = ouser_q; ovalid_d = ovalid_q;
    ctrl = '0;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          if (s_axis_tdata[8]) begin
            if (tot_q < LW'(MESSAGE_BYTES)) tot_d = tot_q + LW'(1);
            else ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            if (ovf_d) begin
              state_d = S_ERR;
            end else begin
              cnt_d = KW'(1); got_d = '0; pos_d = '0; fill_d = '0;
              ctrl.init = 1'b1;
              state_d = S_WAIT;
            end
          end
        end
      end
      S_WAIT: begin
        // Wait state so the first store read is valid.
        pos_d = pos_q;
        state_d = S_FEED;
      end
      S_FEED: begin
        blk_d[511 - 8*fill_q -: 8] = feed_byte;
        pos_d = pos_q + (LW+4)'(1);
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          state_d = S_COMP;
        end
      end
      S_COMP: begin
        if (fill_q == 6'd0 && !core_busy && !rd_valid_q) begin
          ctrl.start = 1'b1;
        end else if (!core_busy && rd_valid_q) begin
          if (pos_q == padlen_q) begin
            dig_d = digest; word_d = '0;
            state_d = S_EMIT;
          end else begin
            state_d = S_FEED;
          end
        end
      end
      S_EMIT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          out_d = {4'd0, nbytes, kw};
          ouser_d = 1'b0;
          got_d = got_q + KW'(nbytes);
          olast_d = (got_d == need);
          word_d = word_q + 2'd1;
          if (got_d == need) begin
            tot_d = '0; ovf_d = 1'b0;
            state_d = S_LOAD;
          end else if (word_q == 2'd3) begin
            cnt_d = cnt_q + KW'(1); pos_d = '0; fill_d = '0;
            ctrl.init = 1'b1;
            state_d = S_WAIT;
          end
        end
      end
      S_ERR: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1; out_d = '0; olast_d = 1'b1; ouser_d = 1'b1;
          tot_d = '0; ovf_d = 1'b0;
          state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // rd_valid_q marks that the core has been started for the current block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; tot_q <= '0; ovf_q <= 1'b0; ovalid_q <= 1'b0;
      pos_q <= '0; fill_q <= '0; cnt_q <= '0; got_q <= '0; word_q <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; tot_q <= tot_d; ovf_q <= ovf_d; ovalid_q <= ovalid_d;
      pos_q <= pos_d; fill_q <= fill_d; cnt_q <= cnt_d; got_q <= got_d;
      word_q <= word_d;
      rd_valid_q <= ctrl.start ? 1'b1 : (state_d == S_COMP ? rd_valid_q : 1'b0);
    end
  end

  // Padded length: message plus 9 bytes, rounded up to whole blocks.
  always_ff @(posedge clk_i) begin
    padlen_q <= ((msg_end + (LW+4)'(8)) | (LW+4)'(63)) + (LW+4)'(1);
    blk_q <= blk_d; dig_q <= dig_d;
    out_q <= out_d; olast_q <= olast_d; ouser_q <= ouser_d;
  end

endmodule

// File: rtl/ckdf_core.sv
// SHA-256 compression core: one round per cycle on a shared round unit.
`timescale 1ns / 1ps
module ckdf_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ckdf_pkg::core_ctrl_t ctrl_i,
  input  logic [511:0]        block_i,
  output logic                busy_o,
  output logic [255:0]        digest_o
);

  logic [255:0] h_q, h_d;
  logic [31:0]  v_q [8];
  logic [31:0]  v_d [8];
  logic [31:0]  w_q [16];
  logic [31:0]  w_d [16];
  logic [6:0]   rnd_q, rnd_d;
  logic         busy_q, busy_d;

  logic [31:0] e1, ch, t1, a1, mj, s0, s1, wnew;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Round datapath and schedule extension.
  always_comb begin
    e1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + e1 + ch + ckdf_pkg::round_k(rnd_q[5:0]) + w_q[0];
    a1 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
  end

  // Sequencing of the 64 rounds and the final chaining add.
  always_comb begin
    h_d = h_q;
    v_d = v_q;
    w_d = w_q;
    rnd_d = rnd_q;
    busy_d = busy_q;
    if (ctrl_i.init) begin
      h_d = ckdf_pkg::InitH;
    end
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      rnd_d = '0;
      for (int i = 0; i < 8; i++) v_d[i] = h_q[255 - 32*i -: 32];
      for (int i = 0; i < 16; i++) w_d[i] = block_i[511 - 32*i -: 32];
    end else if (busy_q) begin
      if (rnd_q == 7'd64) begin
        for (int i = 0; i < 8; i++) h_d[255 - 32*i -: 32] = h_q[255 - 32*i -: 32] + v_q[i];
        busy_d = 1'b0;
      end else begin
        v_d[7] = v_q[6]; v_d[6] = v_q[5]; v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2]; v_d[2] = v_q[1]; v_d[1] = v_q[0];
        v_d[0] = t1 + a1 + mj;
        for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
        w_d[15] = wnew;
        rnd_d = rnd_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      busy_q <= busy_d;
      rnd_q  <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    v_q <= v_d;
    w_q <= w_d;
  end

  assign busy_o   = busy_q;
  assign digest_o = h_q;

endmodule

// File: bench/ckdf_checker.sv
// Checker for the Concat KDF SHA-256 block: predicts key words and compares them.
`timescale 1ns / 1ps
module ckdf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,     // [7:0] data_byte, [8] byte_present, zero fill
  input  logic        s_tuser_i,     // part_select
  input  logic        s_tlast_i,     // message_end
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [71:0] m_tdata_i,     // [63:0] key_word, [67:64] valid_bytes, zero fill
  input  logic        m_tuser_i,     // overflow_error
  input  logic        m_tlast_i,     // last_word
  output int unsigned errors_o,
  output int unsigned pending_o
);

  localparam int unsigned StoreBytes = 256;
  localparam int unsigned KeyMax     = 512;

  localparam logic [0:63][31:0] RoundConst = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
    logic        ovf;
  } key_word_t;

  logic [7:0]  msg_mem [StoreBytes];
  int unsigned msg_len;
  logic        msg_overflow;
  logic [9:0]  key_len_reg;
  key_word_t   key_words_q[$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 pass over counter, then the stored message, with padding.
  function automatic logic [255:0] pass_digest(input logic [31:0] ctr);
    logic [7:0]  pad_q[$];
    logic [31:0] h [8];
    logic [31:0] v [8];
    logic [31:0] w [64];
    logic [31:0] bits, s0, s1, t1, t2;
    logic [255:0] dig;
    int i, b;
    bits = (4 + msg_len) * 8;
    for (i = 0; i < 4; i++) pad_q.push_back(ctr[31-8*i -: 8]);
    for (i = 0; i < msg_len; i++) pad_q.push_back(msg_mem[i]);
    pad_q.push_back(8'h80);
    while (pad_q.size() % 64 != 56) pad_q.push_back(8'h00);
    for (i = 0; i < 4; i++) pad_q.push_back(8'h00);
    for (i = 0; i < 4; i++) pad_q.push_back(bits[31-8*i -: 8]);
    for (i = 0; i < 8; i++) h[i] = ckdf_pkg::InitH[255-32*i -: 32];
    for (b = 0; b < pad_q.size() / 64; b++) begin
      for (i = 0; i < 16; i++) begin
        w[i] = {pad_q[b*64+4*i], pad_q[b*64+4*i+1], pad_q[b*64+4*i+2], pad_q[b*64+4*i+3]};
      end
      for (i = 16; i < 64; i++) begin
        s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (i = 0; i < 8; i++) v[i] = h[i];
      for (i = 0; i < 64; i++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (i = 0; i < 8; i++) h[i] = h[i] + v[i];
    end
    for (i = 0; i < 8; i++) dig[255-32*i -: 32] = h[i];
    return dig;
  endfunction

  // Derive the key for the stored message and queue its words.
  task automatic derive_key();
    logic [7:0]   key_q[$];
    logic [255:0] dig;
    logic [31:0]  ctr;
    int unsigned  klen, nwords, k, j, n;
    key_word_t    kw;
    klen = key_len_reg;
    if (klen == 0) klen = 1;
    if (klen > KeyMax) klen = KeyMax;
    ctr = 1;
    while (key_q.size() < klen) begin
      dig = pass_digest(ctr);
      for (j = 0; j < 32; j++) if (key_q.size() < klen) key_q.push_back(dig[255-8*j -: 8]);
      ctr++;
    end
    nwords = (klen + 7) / 8;
    for (k = 0; k < nwords; k++) begin
      n = (klen - k * 8 > 8) ? 8 : klen - k * 8;
      kw = '0;
      for (j = 0; j < 8; j++) kw.word = {kw.word[55:0], (j < n) ? key_q[k*8+j] : 8'h00};
      kw.nbytes = 4'(n);
      kw.last   = (k + 1 == nwords);
      key_words_q.push_back(kw);
    end
  endtask

  // Watch both channels and the register port.
  always @(posedge clk_i or negedge rst_ni) begin
    key_word_t exp_w;
    if (!rst_ni) begin
      msg_len      = 0;
      msg_overflow = 1'b0;
      key_len_reg  = ckdf_pkg::KeyLenReset;
      errors_o     = 0;
      key_words_q.delete();
      pending_o    = 0;
    end else begin
      if (cfg_we_i) key_len_reg = cfg_wdata_i;
      // Output transfer: compare against the oldest expected word.
      if (m_tvalid_i && m_tready_i) begin
        if (key_words_q.size() == 0) begin
          $display("%0t: unexpected key word %h", $time, m_tdata_i);
          errors_o++;
        end else begin
          exp_w = key_words_q.pop_front();
          if (m_tdata_i[63:0] !== exp_w.word) begin
            $display("%0t: key_word expected %h actual %h", $time, exp_w.word, m_tdata_i[63:0]);
            errors_o++;
          end
          if (m_tdata_i[67:64] !== exp_w.nbytes) begin
            $display("%0t: valid_bytes expected %0d actual %0d", $time, exp_w.nbytes,
                     m_tdata_i[67:64]);
            errors_o++;
          end
          if (m_tlast_i !== exp_w.last) begin
            $display("%0t: last_word expected %b actual %b", $time, exp_w.last, m_tlast_i);
            errors_o++;
          end
          if (m_tuser_i !== exp_w.ovf) begin
            $display("%0t: overflow_error expected %b actual %b", $time, exp_w.ovf, m_tuser_i);
            errors_o++;
          end
        end
      end
      // Input transfer: store the byte, derive on message end.
      if (s_tvalid_i && s_tready_i) begin
        if (s_tdata_i[8]) begin
          if (msg_len < StoreBytes) begin
            msg_mem[msg_len] = s_tdata_i[7:0];
            msg_len++;
          end else begin
            msg_overflow = 1'b1;
          end
        end
        if (s_tlast_i) begin
          if (msg_overflow) begin
            exp_w      = '0;
            exp_w.last = 1'b1;
            exp_w.ovf  = 1'b1;
            key_words_q.push_back(exp_w);
          end else begin
            derive_key();
          end
          msg_len      = 0;
          msg_overflow = 1'b0;
        end
      end
      pending_o = key_words_q.size();
    end
  end

endmodule

// File: bench/tb_concat_kdf_sha256_top.sv
// Testbench top for the Concat KDF SHA-256 block: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_concat_kdf_sha256_top;

  localparam int unsigned CycleLimit = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [9:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;     // [7:0] data_byte, [8] byte_present, zero fill
  logic        s_axis_tuser;     // part_select
  logic        s_axis_tlast;     // message_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;     // [63:0] key_word, [67:64] valid_bytes, zero fill
  logic        m_axis_tuser;     // overflow_error
  logic        m_axis_tlast;     // last_word
  int unsigned errors;
  int unsigned pending;
  int unsigned items_sent;
  int unsigned cycles;

  concat_kdf_sha256_top i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  ckdf_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .s_tuser_i(s_axis_tuser), .s_tlast_i(s_axis_tlast),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .m_tuser_i(m_axis_tuser), .m_tlast_i(m_axis_tlast),
    .errors_o(errors), .pending_o(pending)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Key word receiver with random stalls and one long hold-off in the middle of the
  // first key, while the next message is already being offered.
  initial begin
    int unsigned stall, words_taken, quiet_left;
    words_taken   = 0;
    quiet_left    = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (words_taken == 2) stall = 400;
      else if (quiet_left > 0) begin
        quiet_left--;
        stall = 0;
      end else begin
        if ($urandom_range(0, 29) == 0) quiet_left = 20;
        stall = $urandom_range(0, 12);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      words_taken++;
    end
  end

  int unsigned send_quiet;

  // Offer one item and wait for its transfer.
  task automatic send_item(input logic [7:0] data, input logic part, input logic present,
                           input logic last);
    int unsigned gap;
    if (send_quiet > 0) begin
      send_quiet--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 29) == 0) send_quiet = 20;
      gap = $urandom_range(0, 12);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, present, data};
    s_axis_tuser  <= part;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Write the key length once the block has drained.
  task automatic write_key_length(input logic [9:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // A message of len items: secret bytes then otherinfo, with optional noise.
  task automatic send_message(input int unsigned len, input bit noisy);
    int unsigned k, split;
    logic part, present;
    split = $urandom_range(0, len);
    for (k = 0; k < len; k++) begin
      part    = (k >= split);
      present = 1'b1;
      if (noisy && $urandom_range(0, 14) == 0) part = ~part;
      if (noisy && $urandom_range(0, 11) == 0) present = 1'b0;
      if (noisy && k + 1 == len) present = 1'($urandom_range(0, 1));
      send_item(8'($urandom_range(0, 255)), part, present, k + 1 == len);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int unsigned msg_idx, r;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    items_sent    = 0;
    send_quiet    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset key length: extreme bytes, both parts.
    send_item(8'h00, 1'b0, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1, 1'b1);
    // Empty message: hash of the counter alone.
    send_item(8'h00, 1'b0, 1'b0, 1'b1);
    // Empty marker inside a message, and a secret byte after otherinfo began.
    send_item(8'h5a, 1'b0, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b1, 1'b0);
    send_item(8'h3c, 1'b0, 1'b1, 1'b0);
    send_item(8'hc3, 1'b1, 1'b1, 1'b1);
    // Smallest key, with the end item carrying no byte.
    write_key_length(10'd1);
    send_item(8'h11, 1'b0, 1'b1, 1'b0);
    send_item(8'h22, 1'b1, 1'b0, 1'b1);
    // Zero key length counts as one byte.
    write_key_length(10'd0);
    send_item(8'h33, 1'b0, 1'b1, 1'b1);
    // Key length above the maximum saturates.
    write_key_length(10'd1023);
    send_item(8'h44, 1'b0, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b1, 1'b1);
    write_key_length(10'd512);
    send_item(8'h66, 1'b1, 1'b1, 1'b1);
    write_key_length(10'd33);
    send_item(8'h77, 1'b0, 1'b1, 1'b1);

    // Random messages; the first overflows the store and the second spans three blocks.
    msg_idx = 0;
    while (items_sent < 400) begin
      r = $urandom_range(0, 9);
      if (r == 0) write_key_length(10'($urandom_range(0, 1023)));
      else if (r == 1) write_key_length(10'd512);
      else write_key_length(10'($urandom_range(1, 64)));
      if (msg_idx == 0) send_message(262, 1'b0);
      else if (msg_idx == 1) send_message(120, 1'b0);
      else send_message($urandom_range(1, 60), 1'b1);
      msg_idx++;
    end

    // Drain and give the verdict.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
